@@ hdl/jfs_pkg.sv @@
// Shared types and constants for the two-machine flow shop scheduler.
package jfs_pkg;

  localparam int unsigned MaxJobsDefault = 64;
  localparam int unsigned IdW            = 16;
  localparam int unsigned TimeW          = 16;
  localparam int unsigned SchedW         = 24;

  typedef struct packed {
    logic [IdW-1:0]   job_id;
    logic [TimeW-1:0] time_on_b;
    logic [TimeW-1:0] time_on_c;
    logic             last_job;
  } job_in_t;

  typedef struct packed {
    logic [IdW-1:0]    out_job_id;
    logic [SchedW-1:0] start_on_b;
    logic [SchedW-1:0] start_on_c;
    logic [SchedW-1:0] makespan;
    logic              overflow;
    logic              last_result;
  } job_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // write incoming job
    logic sched_init;  // start the timing pass
    logic emit_init;   // start the emission pass
    logic scan_init;   // restart the selection scan
    logic scan_step;   // read and compare one stored job
    logic pick;        // take the selected job
    logic clear;       // drop the set
  } jfs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic found;
    logic last_pick;
    logic emit_pass;
    logic empty;
  } jfs_stat_t;

endpackage

@@ hdl/jfs_datapath.sv @@
// Job store, ordering, timing and result registers of the flow shop scheduler.
module jfs_datapath import jfs_pkg::*; #(
  parameter int unsigned MAX_JOBS = MaxJobsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  jfs_cmd_t            cmd,
  input  job_in_t             job,
  input  logic [TimeW-1:0]    start_time,
  output jfs_stat_t           stat,
  output logic                result_valid,
  output job_out_t            result
);

  localparam int unsigned AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned KW = TimeW + AW;
  localparam int unsigned EW = IdW + 2*TimeW;

  logic [EW-1:0] store [MAX_JOBS];

  logic [CW-1:0]     count;
  logic              ovf;
  logic [CW-1:0]     scan_addr;
  logic [EW-1:0]     rd_q;
  logic [AW-1:0]     rd_idx;
  logic              rd_v;
  logic              phase_c, has_last, emit_pass, best_found;
  logic [KW-1:0]     last_key, best_key;
  logic [EW-1:0]     best;
  logic [CW-1:0]     picks;
  logic [SchedW-1:0] bt, ct, span;

  logic [TimeW-1:0]  rd_tb, rd_tc, best_tb, best_tc;
  logic [IdW-1:0]    best_id;
  logic              rd_ckey, cand, last_pick, take;
  logic [KW-1:0]     rd_key;
  logic [SchedW-1:0] bt_next, cs_next, ct_next;

  // Key of the job just read: smaller time, then index for stability.
  assign rd_tb   = rd_q[2*TimeW-1:TimeW];
  assign rd_tc   = rd_q[TimeW-1:0];
  assign rd_ckey = rd_tc < rd_tb;
  assign rd_key  = {rd_ckey ? rd_tc : rd_tb, rd_idx};

  // B-keyed jobs go out in ascending key order, then C-keyed ones descending.
  always_comb begin
    if (!phase_c) begin
      cand = !rd_ckey && (!has_last || rd_key > last_key)
                      && (!best_found || rd_key < best_key);
    end else begin
      cand = rd_ckey && (!has_last || rd_key < last_key)
                     && (!best_found || rd_key > best_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (count < CW'(MAX_JOBS)) count <= count + CW'(1);
      else                       ovf   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && count < CW'(MAX_JOBS)) begin
      store[count[AW-1:0]] <= {job.job_id, job.time_on_b, job.time_on_c};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_addr < count) begin
      rd_q   <= store[scan_addr[AW-1:0]];
      rd_idx <= scan_addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      rd_v       <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_addr  <= '0;
      rd_v       <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_v <= (scan_addr < count);
      if (scan_addr < count) scan_addr <= scan_addr + CW'(1);
      if (rd_v && cand) best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_v && cand) begin
      best_key <= rd_key;
      best     <= rd_q;
    end
  end

  assign take = cmd.pick && best_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_pass <= 1'b0;
      phase_c   <= 1'b0;
      has_last  <= 1'b0;
      picks     <= '0;
    end else if (cmd.sched_init || cmd.emit_init) begin
      emit_pass <= cmd.emit_init;
      phase_c   <= 1'b0;
      has_last  <= 1'b0;
      picks     <= '0;
    end else if (cmd.pick) begin
      if (best_found) begin
        has_last <= 1'b1;
        picks    <= picks + CW'(1);
      end else begin
        phase_c  <= 1'b1;
        has_last <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) last_key <= best_key;
  end

  assign best_id = best[EW-1:2*TimeW];
  assign best_tb = best[2*TimeW-1:TimeW];
  assign best_tc = best[TimeW-1:0];

  always_comb begin
    bt_next = bt + SchedW'(best_tb);
    cs_next = (bt_next > ct) ? bt_next : ct;
    ct_next = cs_next + SchedW'(best_tc);
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_init || cmd.emit_init) begin
      bt <= SchedW'(start_time);
      ct <= '0;
    end else if (take) begin
      bt <= bt_next;
      ct <= ct_next;
      if (!emit_pass) span <= ct_next - SchedW'(start_time);
    end
  end

  assign last_pick = (picks + CW'(1) == count);

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= take && emit_pass;
  end

  always_ff @(posedge clk) begin
    if (take && emit_pass) begin
      result.out_job_id  <= best_id;
      result.start_on_b  <= bt;
      result.start_on_c  <= cs_next;
      result.makespan    <= span;
      result.overflow    <= ovf;
      result.last_result <= last_pick;
    end
  end

  assign stat.scan_done = (scan_addr == count) && !rd_v;
  assign stat.found     = best_found;
  assign stat.last_pick = last_pick;
  assign stat.emit_pass = emit_pass;
  assign stat.empty     = (count == '0);

endmodule

@@ hdl/jfs_ctrl.sv @@
// Sequencer for load, sort, timing and emission.
module jfs_ctrl import jfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      last_job,
  input  jfs_stat_t stat,
  output jfs_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SINIT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EINIT = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = (state != S_LOAD);
    unique case (state)
      S_LOAD: begin
        cmd.load = start;
        if (start && last_job) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.empty) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end else begin
          cmd.sched_init = 1'b1;
          state_next     = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end else begin
          cmd.pick = 1'b1;
          if (stat.found && stat.last_pick) begin
            if (stat.emit_pass) begin
              cmd.clear  = 1'b1;
              state_next = S_LOAD;
            end else begin
              state_next = S_EINIT;
            end
          end else begin
            state_next = S_SINIT;
          end
        end
      end
      S_EINIT: begin
        cmd.emit_init = 1'b1;
        state_next    = S_SINIT;
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

@@ hdl/two_machine_flow_shop_scheduler_core.sv @@
// Top level of the two-machine flow shop scheduler (Johnson's rule).
//  channel | handshake             | payload
//  config  | start_time_we         | start_time_wdata
//  jobs    | start & !busy         | job
//  results | result_valid (strobe) | result
// Loading takes one job per cycle while not busy. After the last job, if any
// job is stored: a timing pass, then an emission pass, each of a setup step
// and N selection scans (one more scan when any job is C-keyed), N being the
// jobs stored. Each emission scan that takes a job ends in one result beat.
// Reset clears the job count and overflow flag; start_time resets to 0.
// Results cannot be stalled; busy falls as the last beat is presented.
module two_machine_flow_shop_scheduler_core import jfs_pkg::*; #(
  parameter int unsigned MAX_JOBS = MaxJobsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start_time_we,
  input  logic [TimeW-1:0] start_time_wdata,
  input  logic             start,
  input  job_in_t          job,
  output logic             busy,
  output logic             result_valid,
  output job_out_t         result
);

  logic [TimeW-1:0] start_time;
  jfs_cmd_t         cmd;
  jfs_stat_t        stat;
  logic             ctl_busy;

  always_ff @(posedge clk) begin
    if (rst)                start_time <= '0;
    else if (start_time_we) start_time <= start_time_wdata;
  end

  jfs_ctrl u_ctrl (
    .clk, .rst, .start, .last_job(job.last_job), .stat, .cmd, .busy(ctl_busy)
  );

  jfs_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
    .clk, .rst, .cmd, .job, .start_time, .stat, .result_valid, .result
  );

  assign busy = ctl_busy;

endmodule
